// ===== rtl/image_update_receiver_crc32_core_macros.svh =====
// ----------------------------------------------------------------------------
// Image update receiver: assertion macros
// Shared property forms for the checker of the receiver core.
// ----------------------------------------------------------------------------
`ifndef IMAGE_UPDATE_RECEIVER_CRC32_CORE_MACROS_SVH
`define IMAGE_UPDATE_RECEIVER_CRC32_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IURC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define IURC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/iurc_pkg.sv =====
// ----------------------------------------------------------------------------
// Image update receiver package
// Beat types, phase and opcode codes, and the byte-wide CRC-32 step.
// ----------------------------------------------------------------------------
package iurc_pkg;

   // Session phase; error codes use the same encoding (idle means no error)
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RECV     = 4'd1,
      PH_DONE     = 4'd2,
      PH_BADBEGIN = 4'd3,
      PH_SEQ      = 4'd4,
      PH_SIZE     = 4'd5,
      PH_CRC      = 4'd6,
      PH_WRITE    = 4'd7,
      PH_END      = 4'd8
   } phase_type;

   // Beat kinds
   localparam logic [1:0] FUNC_CTRL = 2'd0;
   localparam logic [1:0] FUNC_DATA = 2'd1;
   localparam logic [1:0] FUNC_DISC = 2'd2;

   // Control opcodes
   localparam logic [7:0] OP_BEGIN = 8'h01;
   localparam logic [7:0] OP_END   = 8'h03;
   localparam logic [7:0] OP_ABORT = 8'h04;

   localparam logic [9:0]  BEGIN_LEN = 10'd9;
   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0] CRC_ALL   = 32'hFFFFFFFF;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  opcode;
      logic [9:0]  ctrl_len;
      logic [31:0] image_size;
      logic [31:0] expected_crc;
      logic [7:0]  data_byte;
      logic        chunk_first;
      logic [9:0]  chunk_len;
      logic        store_ok;
   } req_type;

   typedef struct packed {
      logic [3:0]  phase;
      logic [31:0] bytes_received;
      logic [3:0]  error_code;
      logic        notify;
      logic        ota_active;
   } rsp_type;

   // Reflected CRC-32, one byte, eight bit steps of XOR logic
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc_cur,
                                              input logic [7:0]  data);
      logic [31:0] c;
      c = crc_cur ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage

// ===== rtl/iurc_engine.sv =====
// ----------------------------------------------------------------------------
// Image update receiver: session engine
// Holds the session state and works out the next state and the result of one
// beat combinationally. State commits when the top level advances a beat.
// ----------------------------------------------------------------------------
module iurc_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  iurc_pkg::req_type req,
   output iurc_pkg::rsp_type rsp
);
   import iurc_pkg::*;

   phase_type   phase_ff, phase_in;
   phase_type   error_ff, error_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] tcrc_ff, tcrc_in;
   logic [31:0] crc_ff, crc_in;
   logic        reboot_ff, reboot_in;
   logic        chunk_ff, chunk_in;

   logic        note;
   logic        fail;
   phase_type   fail_code;
   logic        take_byte;
   logic [31:0] remaining;

   assign remaining = size_ff - count_ff;

   // Next state for one beat
   always_comb begin
      phase_in  = phase_ff;
      error_in  = error_ff;
      count_in  = count_ff;
      size_in   = size_ff;
      tcrc_in   = tcrc_ff;
      crc_in    = crc_ff;
      reboot_in = reboot_ff;
      chunk_in  = chunk_ff;
      note      = 1'b0;
      fail      = 1'b0;
      fail_code = PH_SEQ;
      take_byte = 1'b0;

      case (req.func)
         FUNC_CTRL: begin
            if (req.ctrl_len != 10'd0) begin
               note     = 1'b1;
               chunk_in = 1'b0;
               case (req.opcode)
                  OP_BEGIN: begin
                     if (req.ctrl_len != BEGIN_LEN) begin
                        fail      = 1'b1;
                        fail_code = PH_BADBEGIN;
                     end else begin
                        size_in   = req.image_size;
                        tcrc_in   = req.expected_crc;
                        count_in  = 32'd0;
                        crc_in    = CRC_ALL;
                        reboot_in = 1'b0;
                        if (req.image_size == 32'd0 || !req.store_ok) begin
                           fail      = 1'b1;
                           fail_code = PH_BADBEGIN;
                        end else begin
                           error_in = PH_IDLE;
                           phase_in = PH_RECV;
                        end
                     end
                  end
                  OP_END: begin
                     // sequence, size, crc, store: first failure wins
                     if (phase_ff != PH_RECV) begin
                        fail      = 1'b1;
                        fail_code = PH_SEQ;
                     end else if (count_ff != size_ff) begin
                        fail      = 1'b1;
                        fail_code = PH_SIZE;
                     end else if ((crc_ff ^ CRC_ALL) != tcrc_ff) begin
                        fail      = 1'b1;
                        fail_code = PH_CRC;
                     end else if (!req.store_ok) begin
                        fail      = 1'b1;
                        fail_code = PH_END;
                     end else begin
                        phase_in  = PH_DONE;
                        error_in  = PH_IDLE;
                        reboot_in = 1'b1;
                     end
                  end
                  OP_ABORT: begin
                     phase_in  = PH_IDLE;
                     error_in  = PH_IDLE;
                     count_in  = 32'd0;
                     reboot_in = 1'b0;
                  end
                  default: begin
                     fail      = 1'b1;
                     fail_code = PH_SEQ;
                  end
               endcase
            end
         end
         FUNC_DATA: begin
            if (req.chunk_len != 10'd0) begin
               if (req.chunk_first) begin
                  // chunk start: sequence and room, then store acceptance
                  chunk_in = 1'b0;
                  if (phase_ff != PH_RECV || count_ff > size_ff ||
                      {22'd0, req.chunk_len} > remaining) begin
                     fail      = 1'b1;
                     fail_code = PH_SEQ;
                     note      = 1'b1;
                  end else if (!req.store_ok) begin
                     fail      = 1'b1;
                     fail_code = PH_WRITE;
                     note      = 1'b1;
                  end else begin
                     chunk_in  = 1'b1;
                     take_byte = 1'b1;
                  end
               end else if (chunk_ff && phase_ff == PH_RECV && count_ff < size_ff) begin
                  take_byte = 1'b1;
               end
            end
         end
         FUNC_DISC: begin
            chunk_in = 1'b0;
            if (phase_ff == PH_RECV) begin
               fail      = 1'b1;
               fail_code = PH_SEQ;
               note      = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // accepted payload byte
      if (take_byte) begin
         crc_in   = crc32_byte(crc_ff, req.data_byte);
         count_in = count_ff + 32'd1;
      end

      // failure takes phase and error, drops a pending reboot
      if (fail) begin
         reboot_in = 1'b0;
         phase_in  = fail_code;
         error_in  = fail_code;
      end
   end

   // Result for this beat
   always_comb begin
      rsp.phase          = phase_in;
      rsp.bytes_received = count_in;
      rsp.error_code     = error_in;
      rsp.notify         = note;
      rsp.ota_active     = (phase_in == PH_RECV) || reboot_in;
   end

   // Session state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         error_ff  <= PH_IDLE;
         count_ff  <= 32'd0;
         size_ff   <= 32'd0;
         tcrc_ff   <= 32'd0;
         crc_ff    <= CRC_ALL;
         reboot_ff <= 1'b0;
         chunk_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         error_ff  <= error_in;
         count_ff  <= count_in;
         size_ff   <= size_in;
         tcrc_ff   <= tcrc_in;
         crc_ff    <= crc_in;
         reboot_ff <= reboot_in;
         chunk_ff  <= chunk_in;
      end
   end

endmodule

// ===== rtl/image_update_receiver_crc32_core.sv =====
// ----------------------------------------------------------------------------
// Image update receiver with CRC-32 check
// Receiving side of an image-update session: begin/end/abort control, one
// payload byte per beat with a running reflected CRC-32, one result per beat.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload  | direction
//  --------+-----------+-----------+----------+----------
//  request | req_valid | req_stall | req_data | in
//  result  | rsp_valid | rsp_stall | rsp_data | out
//
// One beat per clock sustained while the result channel does not stall; a result
// is offered once its request has passed the input register, then the result register.
// The byte-wide CRC step and the session compare sit between the two
// registers and set the cycle time.
// Reset is synchronous and returns the session to idle with the CRC preset.
// A stalled result holds the result register; the input register keeps
// taking a beat whenever the result register is free or being drained.
// ----------------------------------------------------------------------------
module image_update_receiver_crc32_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iurc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iurc_pkg::rsp_type rsp_data
);
   import iurc_pkg::*;

   logic    in_vld_ff, in_vld_in;
   req_type in_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_ff;
   rsp_type result;
   logic    advance;
   logic    in_take;

   // Beat moves to the result register when that register is free or drains
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign in_take   = req_valid && !req_stall;

   assign in_vld_in  = in_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && rsp_stall);

   iurc_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_ff),
      .rsp     (result)
   );

   // Handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/iurc_checker.sv =====
// ----------------------------------------------------------------------------
// Image update receiver: port checker
// Watches the top-level ports and checks result consistency and hold rules.
// ----------------------------------------------------------------------------
`include "image_update_receiver_crc32_core_macros.svh"

module iurc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input iurc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input iurc_pkg::rsp_type rsp_data
);
   import iurc_pkg::*;

   logic rsp_err;
   logic err_match;
   logic rsp_recv;
   logic phase_legal;
   logic rsp_held;
   logic req_held;

   assign rsp_err     = rsp_valid && rsp_data.error_code != PH_IDLE;
   assign err_match   = rsp_data.error_code == rsp_data.phase;
   assign rsp_recv    = rsp_valid && rsp_data.phase == PH_RECV;
   assign phase_legal = rsp_data.phase <= PH_END;
   assign rsp_held    = rsp_valid && rsp_stall;
   assign req_held    = req_valid && req_stall;

   // a reported error always matches the phase it left behind
   `IURC_ASSERT_IMP(a_err_phase, clock, reset, rsp_err, err_match, "error code off phase")

   // a receiving session is always reported active
   `IURC_ASSERT_IMP(a_recv_active, clock, reset, rsp_recv, rsp_data.ota_active, "not active")

   // no phase code beyond the end failure
   `IURC_ASSERT_IMP(a_phase_range, clock, reset, rsp_valid, phase_legal, "phase out of range")

   // a stalled result beat holds
   `IURC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data), "rsp moved")

   // a stalled request beat holds
   `IURC_ASSERT_NXT(a_req_hold, clock, reset, req_held, req_valid && $stable(req_data), "req moved")

endmodule

bind image_update_receiver_crc32_core iurc_checker u_iurc_checker (.*);

// ===== verif/image_update_receiver_crc32_core_tb.sv =====
// ----------------------------------------------------------------------------
// Image update receiver: self-checking testbench
// Drives sessions of begin, payload chunks and end, along with malformed and
// interleaved beats, through the request channel. A local copy of the session
// logic predicts the status word for every accepted beat, and the result
// channel is checked against it, one field at a time and in order. Both
// channels idle and stall at random, and one long receiver hold-off lets the
// core fill up and push back on its input.
// ----------------------------------------------------------------------------
module image_update_receiver_crc32_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import iurc_pkg::*;

   localparam int unsigned RANDOM_BEATS = 700;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned REPORT_LIMIT = 10;

   // Beat kind that the core ignores
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Beats waiting to be offered, and status words waiting to come back
   req_type pending_beats[$];
   rsp_type expected_status[$];

   int unsigned fail_count = 0;
   int unsigned status_seen = 0;
   int unsigned idle_cycles = 0;

   // Session state of the local prediction
   phase_type   sess_phase = PH_IDLE;
   phase_type   sess_error = PH_IDLE;
   logic [31:0] rx_count = '0;
   logic [31:0] goal_size = '0;
   logic [31:0] goal_crc = '0;
   logic [31:0] crc_acc = CRC_ALL;
   bit          reboot_wait = 1'b0;
   bit          chunk_ok = 1'b0;

   image_update_receiver_crc32_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Reflected CRC-32, data bits fed LSB first one at a time
   function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] d);
      logic [31:0] c;
      c = acc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ d[i]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic void fail_session(input phase_type code);
      reboot_wait = 1'b0;
      sess_phase = code;
      sess_error = code;
   endfunction

   // Advance the session by one beat and return the status it reports
   function automatic rsp_type predict_status(input req_type b);
      rsp_type r;
      bit      note;
      bit      take_byte;
      note = 1'b0;
      take_byte = 1'b0;
      case (b.func)
         FUNC_CTRL: begin
            if (b.ctrl_len != '0) begin
               note = 1'b1;
               chunk_ok = 1'b0;
               if (b.opcode == OP_BEGIN) begin
                  if (b.ctrl_len != BEGIN_LEN) begin
                     fail_session(PH_BADBEGIN);
                  end else begin
                     goal_size = b.image_size;
                     goal_crc = b.expected_crc;
                     rx_count = '0;
                     crc_acc = CRC_ALL;
                     reboot_wait = 1'b0;
                     if (b.image_size == '0 || !b.store_ok) begin
                        fail_session(PH_BADBEGIN);
                     end else begin
                        sess_error = PH_IDLE;
                        sess_phase = PH_RECV;
                     end
                  end
               end else if (b.opcode == OP_END) begin
                  if (sess_phase != PH_RECV) begin
                     fail_session(PH_SEQ);
                  end else if (rx_count != goal_size) begin
                     fail_session(PH_SIZE);
                  end else if ((crc_acc ^ CRC_ALL) != goal_crc) begin
                     fail_session(PH_CRC);
                  end else if (!b.store_ok) begin
                     fail_session(PH_END);
                  end else begin
                     sess_phase = PH_DONE;
                     sess_error = PH_IDLE;
                     reboot_wait = 1'b1;
                  end
               end else if (b.opcode == OP_ABORT) begin
                  sess_phase = PH_IDLE;
                  sess_error = PH_IDLE;
                  rx_count = '0;
                  reboot_wait = 1'b0;
               end else begin
                  fail_session(PH_SEQ);
               end
            end
         end
         FUNC_DATA: begin
            if (b.chunk_len != '0) begin
               if (b.chunk_first) begin
                  chunk_ok = 1'b0;
                  if (sess_phase != PH_RECV || rx_count > goal_size ||
                      32'(b.chunk_len) > goal_size - rx_count) begin
                     fail_session(PH_SEQ);
                     note = 1'b1;
                  end else if (!b.store_ok) begin
                     fail_session(PH_WRITE);
                     note = 1'b1;
                  end else begin
                     chunk_ok = 1'b1;
                     take_byte = 1'b1;
                  end
               end else if (chunk_ok && sess_phase == PH_RECV && rx_count < goal_size) begin
                  take_byte = 1'b1;
               end
               if (take_byte) begin
                  crc_acc = crc_step(crc_acc, b.data_byte);
                  rx_count = rx_count + 32'd1;
               end
            end
         end
         FUNC_DISC: begin
            chunk_ok = 1'b0;
            if (sess_phase == PH_RECV) begin
               fail_session(PH_SEQ);
               note = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.phase = sess_phase;
      r.bytes_received = rx_count;
      r.error_code = sess_error;
      r.notify = note;
      r.ota_active = (sess_phase == PH_RECV) || reboot_wait;
      return r;
   endfunction

   // Beat with every field random, any beat kind
   function automatic req_type noise_beat();
      req_type b;
      b.func = 2'($urandom_range(0, 3));
      b.opcode = 8'($urandom);
      b.ctrl_len = 10'($urandom);
      b.image_size = $urandom;
      b.expected_crc = $urandom;
      b.data_byte = 8'($urandom);
      b.chunk_first = 1'($urandom);
      b.chunk_len = 10'($urandom);
      b.store_ok = 1'($urandom);
      return b;
   endfunction

   task automatic push_ctrl(input logic [7:0] op, input logic [9:0] len,
                            input logic [31:0] size, input logic [31:0] crc, input bit ok);
      req_type b;
      b = noise_beat();
      b.func = FUNC_CTRL;
      b.opcode = op;
      b.ctrl_len = len;
      b.image_size = size;
      b.expected_crc = crc;
      b.store_ok = ok;
      pending_beats.push_back(b);
   endtask

   task automatic push_byte(input logic [7:0] d, input bit first, input logic [9:0] len,
                            input bit ok);
      req_type b;
      b = noise_beat();
      b.func = FUNC_DATA;
      b.data_byte = d;
      b.chunk_first = first;
      b.chunk_len = len;
      b.store_ok = ok;
      pending_beats.push_back(b);
   endtask

   task automatic push_disc();
      req_type b;
      b = noise_beat();
      b.func = FUNC_DISC;
      pending_beats.push_back(b);
   endtask

   // Full session: begin, chunked payload, end; one noise beat lands before
   // byte glitch_at when that index is within the session
   task automatic push_session(input int unsigned n, input int unsigned max_chunk,
                               input bit crc_good, input bit end_ok,
                               input int unsigned glitch_at);
      logic [7:0]  img[$];
      logic [31:0] acc;
      logic [7:0]  d;
      int unsigned left_in_chunk;
      int unsigned chunk_size;
      acc = CRC_ALL;
      for (int unsigned i = 0; i < n; i++) begin
         d = 8'($urandom);
         img.push_back(d);
         acc = crc_step(acc, d);
      end
      acc = acc ^ CRC_ALL;
      if (!crc_good) begin
         acc = acc ^ (32'd1 << $urandom_range(0, 31));
      end
      push_ctrl(OP_BEGIN, BEGIN_LEN, n, acc, 1'b1);
      left_in_chunk = 0;
      for (int unsigned i = 0; i < n; i++) begin
         if (i == glitch_at) begin
            pending_beats.push_back(noise_beat());
         end
         if (left_in_chunk == 0) begin
            chunk_size = $urandom_range(1, max_chunk);
            if (chunk_size > n - i) begin
               chunk_size = n - i;
            end
            left_in_chunk = chunk_size;
            // now and then the chunk claims more bytes than it carries
            push_byte(img[i], 1'b1,
                      10'(($urandom_range(0, 19) == 0) ? chunk_size + $urandom_range(1, 4)
                                                       : chunk_size),
                      $urandom_range(0, 30) != 0);
         end else begin
            push_byte(img[i], 1'b0, 10'($urandom_range(1, 1023)), 1'b1);
         end
         left_in_chunk--;
      end
      if (glitch_at == n) begin
         pending_beats.push_back(noise_beat());
      end
      push_ctrl(OP_END, 10'($urandom_range(1, 1023)), $urandom, $urandom, end_ok);
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Sender: bursts of beats with random gaps; prediction at acceptance
   always @(posedge clock) begin : req_side
      logic        next_valid;
      req_type     next_data;
      int unsigned burst_left;
      int unsigned gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         next_data = req_data;
         if (req_valid && !req_stall) begin
            expected_status.push_back(predict_status(req_data));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_beats.size() > 0) begin
               next_data = pending_beats.pop_front();
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         req_valid <= next_valid;
         req_data <= next_data;
      end
   end

   // Receiver: checks each status beat and stalls on its own pattern
   always @(posedge clock) begin : rsp_side
      rsp_type        want;
      logic           next_stall;
      stall_mode_type stall_mode;
      int unsigned    mode_left;
      int unsigned    hold_left;
      bit             hold_done;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode = STALL_NONE;
         mode_left = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            status_seen++;
            if (expected_status.size() == 0) begin
               note_failure($sformatf("status beat with nothing expected: phase %0d count %0d",
                                      rsp_data.phase, rsp_data.bytes_received));
            end else begin
               want = expected_status.pop_front();
               if (rsp_data.phase !== want.phase ||
                   rsp_data.bytes_received !== want.bytes_received ||
                   rsp_data.error_code !== want.error_code ||
                   rsp_data.notify !== want.notify ||
                   rsp_data.ota_active !== want.ota_active) begin
                  note_failure($sformatf({"status %0d mismatch: phase %0d/%0d count %0d/%0d ",
                                          "error %0d/%0d notify %0b/%0b active %0b/%0b ",
                                          "(expected/actual)"},
                                         status_seen, want.phase, rsp_data.phase,
                                         want.bytes_received, rsp_data.bytes_received,
                                         want.error_code, rsp_data.error_code,
                                         want.notify, rsp_data.notify,
                                         want.ota_active, rsp_data.ota_active));
               end
            end
         end

         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 150);
            stall_mode = stall_mode_type'($urandom_range(0, 3));
         end else begin
            mode_left--;
         end

         // one long hold-off so the core backs up into the request channel
         if (!hold_done && status_seen >= 150) begin
            hold_left = 120;
            hold_done = 1'b1;
         end

         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else begin
            case (stall_mode)
               STALL_NONE:  next_stall = 1'b0;
               STALL_LIGHT: next_stall = ($urandom_range(0, 3) == 0);
               STALL_HEAVY: next_stall = ($urandom_range(0, 3) != 0);
               default:     next_stall = ~rsp_stall;
            endcase
         end
         rsp_stall <= next_stall;
      end
   end

   // Watchdog on cycles with no beat moving on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $realtime, idle_cycles);
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      int unsigned directed_count;
      int unsigned n;

      // idle corner beats: disconnect, unused kind, empty control write
      push_disc();
      begin : unused_kind
         req_type b;
         b = noise_beat();
         b.func = FUNC_UNUSED;
         pending_beats.push_back(b);
      end
      push_ctrl(OP_BEGIN, 10'd0, 32'd4, 32'd0, 1'b1);

      // rejected begins and unknown opcodes
      push_ctrl(OP_BEGIN, 10'd8, 32'd4, 32'd0, 1'b1);
      push_ctrl(OP_BEGIN, BEGIN_LEN, 32'd0, 32'hFFFF_FFFF, 1'b1);
      push_ctrl(OP_BEGIN, BEGIN_LEN, 32'd5, 32'd0, 1'b0);
      push_ctrl(8'hFF, 10'd1023, 32'd0, 32'd0, 1'b1);
      push_ctrl(8'h00, 10'd512, 32'd0, 32'd0, 1'b1);

      // end and chunk start while not receiving
      push_ctrl(OP_END, BEGIN_LEN, 32'd0, 32'd0, 1'b1);
      push_byte(8'h5A, 1'b1, 10'd1, 1'b1);

      // largest image: widest chunk, empty chunk, then end on a short count
      push_ctrl(OP_BEGIN, BEGIN_LEN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      push_byte(8'hFF, 1'b1, 10'd1023, 1'b1);
      push_byte(8'h00, 1'b0, 10'd1, 1'b1);
      push_byte(8'hA5, 1'b1, 10'd0, 1'b1);
      push_byte(8'h3C, 1'b0, 10'd5, 1'b1);
      push_ctrl(OP_END, BEGIN_LEN, 32'd0, 32'd0, 1'b1);
      push_byte(8'h11, 1'b0, 10'd5, 1'b1);

      // chunk longer than what is left, and a refused chunk write
      push_ctrl(OP_BEGIN, BEGIN_LEN, 32'd2, 32'd0, 1'b1);
      push_byte(8'h01, 1'b1, 10'd3, 1'b1);
      push_ctrl(OP_BEGIN, BEGIN_LEN, 32'd2, 32'd0, 1'b1);
      push_byte(8'h02, 1'b1, 10'd2, 1'b0);

      // byte past the image size is dropped; end fails on the CRC check before the store refusal
      push_ctrl(OP_BEGIN, BEGIN_LEN, 32'd1, 32'd0, 1'b1);
      push_byte(8'h80, 1'b1, 10'd1, 1'b1);
      push_byte(8'h81, 1'b0, 10'd1, 1'b1);
      push_ctrl(OP_END, BEGIN_LEN, 32'd0, 32'd0, 1'b0);

      // disconnect mid-session, then abort
      push_ctrl(OP_BEGIN, BEGIN_LEN, 32'd3, 32'd0, 1'b1);
      push_disc();
      push_ctrl(OP_ABORT, 10'd1, 32'd0, 32'd0, 1'b1);

      // clean and bad CRC sessions, then a clean one whose pending reboot an abort clears
      push_session(4, 2, 1'b1, 1'b1, 100);
      push_session(3, 3, 1'b0, 1'b1, 100);
      push_session(2, 1, 1'b1, 1'b1, 100);
      push_ctrl(OP_ABORT, 10'd1023, 32'd0, 32'd0, 1'b0);

      // random part: mostly well-formed sessions, some broken, some noise
      directed_count = pending_beats.size();
      while (pending_beats.size() < directed_count + RANDOM_BEATS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: begin
               n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 16);
               push_session(n, ($urandom_range(0, 3) == 0) ? 512 : $urandom_range(1, 6),
                            $urandom_range(0, 7) != 0, $urandom_range(0, 15) != 0,
                            ($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : n + 1);
            end
            7: push_ctrl(OP_ABORT, 10'($urandom_range(1, 1023)), $urandom, $urandom,
                         1'($urandom));
            default: begin
               repeat ($urandom_range(1, 4)) pending_beats.push_back(noise_beat());
            end
         endcase
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_valid || expected_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_status.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/iurc_pkg.sv
rtl/iurc_engine.sv
rtl/image_update_receiver_crc32_core.sv
rtl/iurc_checker.sv
verif/image_update_receiver_crc32_core_tb.sv
